[rtl/core/dirty_row_span_merger_assert.svh]
// Assertion macros for the checker file.
`ifndef DIRTY_ROW_SPAN_MERGER_ASSERT_SVH
`define DIRTY_ROW_SPAN_MERGER_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define DRSM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("drsm assertion failed");

// Same, on the block's own clock and reset.
`define DRSM_CHECK(lbl, prop) `DRSM_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

[rtl/core/drsm_pkg.sv]
package drsm_pkg;

    localparam int MAX_SPANS = 16;
    localparam int MAX_ROWS  = 1024;

    localparam int X_W     = 13;
    localparam int H_W     = 11;
    localparam int GAP_W   = 16;
    localparam int CNT_W   = $clog2(MAX_SPANS + 1);
    localparam int IDX_W   = $clog2(MAX_SPANS);
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROWC_W  = $clog2(MAX_ROWS + 1);
    localparam int SADDR_W = $clog2(MAX_ROWS * MAX_SPANS);

    localparam logic [X_W-1:0] WIDTH_RESET  = X_W'(4096);
    localparam logic [H_W-1:0] HEIGHT_RESET = H_W'(1024);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic [9:0]         read_row;
    } t_item;

    typedef struct packed {
        logic [1:0]     status;
        logic           span_valid;
        logic [X_W-1:0] span_start;
        logic [X_W-1:0] span_stop;
        logic           last;
        logic           all_clean;
    } t_result;

    // One merge step decision.
    typedef struct packed {
        logic           emit;
        logic           adv;
        logic           join_span;
        logic           to_post;
        logic           done;
        logic [X_W-1:0] e_st;
        logic [X_W-1:0] e_sp;
        logic [X_W-1:0] ns;
        logic [X_W-1:0] ne;
    } t_step;

endpackage

[rtl/core/drsm_merge_step.sv]
module drsm_merge_step (
    input  logic [drsm_pkg::X_W-1:0]   i_st,
    input  logic [drsm_pkg::X_W-1:0]   i_sp,
    input  logic [drsm_pkg::CNT_W-1:0] i_idx,
    input  logic [drsm_pkg::CNT_W-1:0] i_cnt,
    input  logic [drsm_pkg::X_W-1:0]   i_ns,
    input  logic [drsm_pkg::X_W-1:0]   i_ne,
    input  logic                       i_joinph,
    input  logic                       i_post,
    output drsm_pkg::t_step            o_step
);

    logic have;

    assign have = (i_idx < i_cnt);

    // Decide one step of the walk over a row's old spans
    always_comb begin
        o_step = '0;
        o_step.ns = i_ns;
        o_step.ne = i_ne;
        o_step.e_st = i_st;
        o_step.e_sp = i_sp;
        priority if (i_post) begin
            if (have) begin
                o_step.emit = 1'b1;
                o_step.adv = 1'b1;
            end else begin
                o_step.done = 1'b1;
            end
        end else if (!i_joinph && have && (i_sp < i_ns)) begin
            o_step.emit = 1'b1;
            o_step.adv = 1'b1;
        end else if (have && (i_st <= i_ne)) begin
            o_step.join_span = 1'b1;
            o_step.adv = 1'b1;
            o_step.ns = (i_st < i_ns) ? i_st : i_ns;
            o_step.ne = (i_sp > i_ne) ? i_sp : i_ne;
        end else begin
            o_step.emit = 1'b1;
            o_step.to_post = 1'b1;
            o_step.e_st = i_ns;
            o_step.e_sp = i_ne;
        end
    end

endmodule

[rtl/core/dirty_row_span_merger.sv]
// Dirty row span merger. Keeps per row a sorted list of up to MAX_SPANS dirty
// intervals and merges clamped rectangles into it. Every item gives its results
// as one-cycle o_strobe pulses that cannot be held off; busy is high while an
// item is in work. After reset the span counts are swept to zero row by row
// with busy high; a clear runs the same sweep. A read fetches the row's count,
// then fetches and returns its spans one at a time. An add, per covered row,
// reads the count, loads the row's spans, walks them through the single compare
// unit and then stores the count; rows are done one after the other. Empty
// rectangles, reads beyond the height and unused modes answer straight from idle.
module dirty_row_span_merger (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  drsm_pkg::t_item            i_item,
    output logic                       o_strobe,
    output drsm_pkg::t_result          o_result,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [drsm_pkg::X_W-1:0]   i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SWEEP  = 4'd1;
    localparam logic [3:0] S_CNT_RD = 4'd2;
    localparam logic [3:0] S_CNT_WT = 4'd3;
    localparam logic [3:0] S_LD_RD  = 4'd4;
    localparam logic [3:0] S_LD_WT  = 4'd5;
    localparam logic [3:0] S_MERGE  = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;

    localparam int XW = drsm_pkg::X_W;
    localparam int CW = drsm_pkg::CNT_W;
    localparam int YW = drsm_pkg::ROWC_W;
    localparam int GW = drsm_pkg::GAP_W;
    localparam int AW = drsm_pkg::SADDR_W;
    localparam int RW = drsm_pkg::ROW_W;
    localparam int IW = drsm_pkg::IDX_W;

    logic [3:0]          r_state;
    logic [XW-1:0]       r_width;
    logic [drsm_pkg::H_W-1:0] r_height;
    logic                r_clean;
    logic                r_clr_item;
    logic                r_is_read;
    logic [YW-1:0]       r_y;
    logic [YW-1:0]       r_yend;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_m;
    logic [XW-1:0]       r_prev;
    logic [XW-1:0]       r_ns0;
    logic [XW-1:0]       r_ne0;
    logic [XW-1:0]       r_ns;
    logic [XW-1:0]       r_ne;
    logic [XW-1:0]       r_first;
    logic [XW-1:0]       r_last;
    logic                r_joinph;
    logic                r_joined;
    logic                r_post;
    logic [XW-1:0]       r_st [drsm_pkg::MAX_SPANS];
    logic [XW-1:0]       r_sp [drsm_pkg::MAX_SPANS];
    logic                r_strobe;
    drsm_pkg::t_result   r_res;
    logic [CW-1:0]       r_cnt_q;
    logic [2*GW-1:0]     r_sq;

    logic [CW-1:0]       cnt_mem [drsm_pkg::MAX_ROWS];
    logic [2*GW-1:0]     span_mem [drsm_pkg::MAX_ROWS * drsm_pkg::MAX_SPANS];

    logic [YW-1:0]       rows_in_use;
    logic signed [17:0]  c_l, c_t, c_r, c_b;
    logic                rect_empty;
    logic                read_beyond;
    logic [AW-1:0]       row_base;
    logic [AW-1:0]       sp_ra;
    logic                sp_we;
    logic [AW-1:0]       sp_wa;
    logic [2*GW-1:0]     sp_wd;
    logic                cnt_we;
    logic [CW-1:0]       cnt_wd;
    logic                collapse;
    logic [XW-1:0]       col_st, col_sp;
    logic [XW-1:0]       ld_st, ld_sp;
    logic                ld_last;
    logic                row_last;
    drsm_pkg::t_step     stp;

    assign busy = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // Clamp the rectangle to the screen
    always_comb begin
        rows_in_use = (13'(r_height) < 13'(drsm_pkg::MAX_ROWS)) ? YW'(r_height)
                                                                 : YW'(drsm_pkg::MAX_ROWS);
        c_l = (i_item.rect_left < 0) ? 18'sd0 : 18'(i_item.rect_left);
        c_t = (i_item.rect_top < 0) ? 18'sd0 : 18'(i_item.rect_top);
        c_r = (18'(i_item.rect_right) > $signed(18'(r_width)))
            ? $signed(18'(r_width)) : 18'(i_item.rect_right);
        c_b = (18'(i_item.rect_bottom) > $signed(18'(rows_in_use)))
            ? $signed(18'(rows_in_use)) : 18'(i_item.rect_bottom);
        rect_empty = (c_l >= c_r) || (c_t >= c_b);
        read_beyond = (13'(i_item.read_row) >= 13'(rows_in_use));
    end

    // Step through the old spans of the current row
    drsm_merge_step u_step (
        .i_st     (r_st[r_i[IW-1:0]]),
        .i_sp     (r_sp[r_i[IW-1:0]]),
        .i_idx    (r_i),
        .i_cnt    (r_n),
        .i_ns     (r_ns),
        .i_ne     (r_ne),
        .i_joinph (r_joinph),
        .i_post   (r_post),
        .o_step   (stp)
    );

    // Decode the fetched span and build memory writes
    always_comb begin
        row_base = AW'(r_y[RW-1:0]) * AW'(drsm_pkg::MAX_SPANS);
        sp_ra = row_base + AW'(r_i);
        ld_st = r_prev + r_sq[GW+XW-1:GW];
        ld_sp = ld_st + r_sq[XW-1:0];
        ld_last = ((r_i + CW'(1)) == r_n);
        row_last = ((r_y + YW'(1)) == r_yend);
        collapse = !r_joined && (r_n >= CW'(drsm_pkg::MAX_SPANS));
        col_st = (r_ns < r_first) ? r_ns : r_first;
        col_sp = (r_ne > r_last) ? r_ne : r_last;
        sp_we = 1'b0;
        sp_wa = row_base + AW'(r_m);
        sp_wd = {GW'(stp.e_st - r_prev), GW'(stp.e_sp - stp.e_st)};
        if (r_state == S_MERGE) begin
            sp_we = stp.emit && (r_m < CW'(drsm_pkg::MAX_SPANS));
        end else if (r_state == S_FIN) begin
            sp_we = collapse;
            sp_wa = row_base;
            sp_wd = {GW'(col_st), GW'(col_sp - col_st)};
        end
        cnt_we = (r_state == S_SWEEP) || (r_state == S_FIN);
        if (r_state == S_SWEEP) begin
            cnt_wd = '0;
        end else if (collapse) begin
            cnt_wd = CW'(1);
        end else begin
            cnt_wd = r_m;
        end
    end

    // Span and count memories
    always_ff @(posedge i_clk) begin
        if (sp_we) begin
            span_mem[sp_wa] <= sp_wd;
        end
        r_sq <= span_mem[sp_ra];
        if (cnt_we) begin
            cnt_mem[r_y[RW-1:0]] <= cnt_wd;
        end
        r_cnt_q <= cnt_mem[r_y[RW-1:0]];
    end

    // Row span buffer
    always_ff @(posedge i_clk) begin
        if (r_state == S_LD_WT && !r_is_read) begin
            r_st[r_i[IW-1:0]] <= ld_st;
            r_sp[r_i[IW-1:0]] <= ld_sp;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_width <= drsm_pkg::WIDTH_RESET;
            r_height <= drsm_pkg::HEIGHT_RESET;
            r_clean <= 1'b1;
            r_clr_item <= 1'b0;
            r_is_read <= 1'b0;
            r_y <= '0;
            r_yend <= '0;
            r_n <= '0;
            r_i <= '0;
            r_m <= '0;
            r_prev <= '0;
            r_joinph <= 1'b0;
            r_joined <= 1'b0;
            r_post <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            // Configuration writes
            if (i_cfg_we) begin
                if (i_cfg_idx == drsm_pkg::CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= drsm_pkg::H_W'(i_cfg_data);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_res <= '0;
                        r_res.last <= 1'b1;
                        r_res.all_clean <= r_clean;
                        r_is_read <= 1'b0;
                        unique case (i_item.mode)
                            drsm_pkg::MODE_ADD: begin
                                if (rect_empty) begin
                                    r_res.status <= drsm_pkg::STAT_EMPTY;
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_y <= YW'(c_t);
                                    r_yend <= YW'(c_b);
                                    r_ns0 <= XW'(c_l);
                                    r_ne0 <= XW'(c_r);
                                    r_state <= S_CNT_RD;
                                end
                            end
                            drsm_pkg::MODE_CLEAR: begin
                                r_y <= '0;
                                r_clr_item <= 1'b1;
                                r_state <= S_SWEEP;
                            end
                            drsm_pkg::MODE_READ: begin
                                if (read_beyond) begin
                                    r_res.status <= drsm_pkg::STAT_RANGE;
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_y <= YW'(i_item.read_row);
                                    r_is_read <= 1'b1;
                                    r_state <= S_CNT_RD;
                                end
                            end
                            default: begin
                                r_res.status <= drsm_pkg::STAT_EMPTY;
                                r_strobe <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    r_y <= r_y + YW'(1);
                    if (r_y == YW'(drsm_pkg::MAX_ROWS - 1)) begin
                        r_clean <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_clr_item) begin
                            r_clr_item <= 1'b0;
                            r_res <= '0;
                            r_res.status <= drsm_pkg::STAT_DONE;
                            r_res.last <= 1'b1;
                            r_res.all_clean <= 1'b1;
                            r_strobe <= 1'b1;
                        end
                    end
                end
                S_CNT_RD: begin
                    r_state <= S_CNT_WT;
                end
                S_CNT_WT: begin
                    r_n <= r_cnt_q;
                    r_i <= '0;
                    r_m <= '0;
                    r_prev <= '0;
                    r_ns <= r_ns0;
                    r_ne <= r_ne0;
                    r_joinph <= 1'b0;
                    r_joined <= 1'b0;
                    r_post <= 1'b0;
                    if (r_cnt_q != '0) begin
                        r_state <= S_LD_RD;
                    end else if (r_is_read) begin
                        r_strobe <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_MERGE;
                    end
                end
                S_LD_RD: begin
                    r_state <= S_LD_WT;
                end
                S_LD_WT: begin
                    if (r_is_read) begin
                        r_prev <= ld_sp;
                        r_res.span_valid <= 1'b1;
                        r_res.span_start <= ld_st;
                        r_res.span_stop <= ld_sp;
                        r_res.last <= ld_last;
                        r_strobe <= 1'b1;
                        r_i <= r_i + CW'(1);
                        r_state <= ld_last ? S_IDLE : S_LD_RD;
                    end else begin
                        if (r_i == '0) begin
                            r_first <= ld_st;
                        end
                        r_last <= ld_sp;
                        if (ld_last) begin
                            r_i <= '0;
                            r_prev <= '0;
                            r_state <= S_MERGE;
                        end else begin
                            r_prev <= ld_sp;
                            r_i <= r_i + CW'(1);
                            r_state <= S_LD_RD;
                        end
                    end
                end
                S_MERGE: begin
                    // Advance the walk by one decision
                    if (stp.adv) begin
                        r_i <= r_i + CW'(1);
                    end
                    if (stp.join_span) begin
                        r_ns <= stp.ns;
                        r_ne <= stp.ne;
                        r_joined <= 1'b1;
                        r_joinph <= 1'b1;
                    end
                    if (stp.to_post) begin
                        r_post <= 1'b1;
                    end
                    if (stp.emit) begin
                        r_prev <= stp.e_sp;
                        if (r_m < CW'(drsm_pkg::MAX_SPANS)) begin
                            r_m <= r_m + CW'(1);
                        end
                    end
                    if (stp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (row_last) begin
                        r_clean <= 1'b0;
                        r_res.all_clean <= 1'b0;
                        r_strobe <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_y <= r_y + YW'(1);
                        r_state <= S_CNT_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/drsm_checker.sv]
`include "dirty_row_span_merger_assert.svh"

module drsm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              busy,
    input logic              o_strobe,
    input drsm_pkg::t_result o_result
);

    // Hold: a non-done status ends the transaction without a span
    `DRSM_CHECK(a_status_final, o_strobe && (o_result.status != drsm_pkg::STAT_DONE) |-> o_result.last && !o_result.span_valid)

    // Hold: a result without a span is always the last one
    `DRSM_CHECK(a_nospan_last, o_strobe && !o_result.span_valid |-> o_result.last && (o_result.span_start == 0) && (o_result.span_stop == 0))

    // Hold: returned spans are never empty
    `DRSM_CHECK(a_span_order, o_strobe && o_result.span_valid |-> o_result.span_start < o_result.span_stop)

    // Advance: a span that is not last is followed by the next span once it is fetched
    `DRSM_CHECK(a_read_cadence, o_strobe && o_result.span_valid && !o_result.last |-> ##2 o_strobe && o_result.span_valid)

    // Hold: more spans of a row come only while the block stays busy
    `DRSM_CHECK(a_busy_more, o_strobe && !o_result.last |-> busy)

endmodule

bind dirty_row_span_merger drsm_checker u_drsm_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import drsm_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 64;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              o_strobe;
    t_result           o_result;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [X_W-1:0]    i_cfg_data;

    dirty_row_span_merger DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the screen: absolute span bounds per row
    int      shadow_width;
    int      shadow_height;
    int      shadow_count [MAX_ROWS];
    int      shadow_lo    [MAX_ROWS][MAX_SPANS];
    int      shadow_hi    [MAX_ROWS][MAX_SPANS];
    logic    shadow_clean;

    t_result expected_spans [$];
    t_result row_answer     [$];
    int      fail_count;
    int      stall_cycles;

    // Directed stimulus table
    typedef struct {
        t_item   item;
        bit      typed;
        t_result answer;
    } t_directed;

    t_directed directed_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_result make_result(logic [1:0] status, logic valid, int lo, int hi,
                                            logic last, logic clean);
        t_result r;
        r.status = status;
        r.span_valid = valid;
        r.span_start = X_W'(lo);
        r.span_stop = X_W'(hi);
        r.last = last;
        r.all_clean = clean;
        return r;
    endfunction

    function automatic t_item make_item(logic [1:0] mode, int l, int t, int r, int b, int row);
        t_item it;
        it.mode = mode;
        it.rect_left = 16'(l);
        it.rect_top = 16'(t);
        it.rect_right = 16'(r);
        it.rect_bottom = 16'(b);
        it.read_row = 10'(row);
        return it;
    endfunction

    function automatic int rows_in_use();
        return (shadow_height < MAX_ROWS) ? shadow_height : MAX_ROWS;
    endfunction

    // Merge one interval into a row, joining touching spans
    function automatic void merge_interval(int row, int ns, int ne);
        int  n;
        int  m;
        int  i;
        bit  joined;
        int  out_lo [MAX_SPANS+1];
        int  out_hi [MAX_SPANS+1];
        n = shadow_count[row];
        m = 0;
        i = 0;
        joined = 0;
        while (i < n && shadow_hi[row][i] < ns) begin
            out_lo[m] = shadow_lo[row][i];
            out_hi[m] = shadow_hi[row][i];
            m++;
            i++;
        end
        while (i < n && shadow_lo[row][i] <= ne) begin
            if (shadow_lo[row][i] < ns) ns = shadow_lo[row][i];
            if (shadow_hi[row][i] > ne) ne = shadow_hi[row][i];
            joined = 1;
            i++;
        end
        if (!joined && n >= MAX_SPANS) begin
            // Collapse a full row into one covering span
            out_lo[0] = (ns < shadow_lo[row][0]) ? ns : shadow_lo[row][0];
            out_hi[0] = (ne > shadow_hi[row][n-1]) ? ne : shadow_hi[row][n-1];
            m = 1;
        end else begin
            out_lo[m] = ns;
            out_hi[m] = ne;
            m++;
            for (; i < n; i++) begin
                out_lo[m] = shadow_lo[row][i];
                out_hi[m] = shadow_hi[row][i];
                m++;
            end
        end
        if (m > MAX_SPANS) m = MAX_SPANS;
        for (int k = 0; k < m; k++) begin
            shadow_lo[row][k] = out_lo[k];
            shadow_hi[row][k] = out_hi[k];
        end
        shadow_count[row] = m;
    endfunction

    // Apply one transaction to the shadow state; answers go to row_answer
    function automatic void apply_item(t_item it);
        int l;
        int t;
        int r;
        int b;
        int row;
        row_answer.delete();
        case (it.mode)
            MODE_ADD: begin
                l = int'(it.rect_left);
                t = int'(it.rect_top);
                r = int'(it.rect_right);
                b = int'(it.rect_bottom);
                if (l < 0) l = 0;
                if (t < 0) t = 0;
                if (r > shadow_width) r = shadow_width;
                if (b > rows_in_use()) b = rows_in_use();
                if (l >= r || t >= b) begin
                    row_answer.push_back(make_result(STAT_EMPTY, 0, 0, 0, 1, shadow_clean));
                end else begin
                    for (int y = t; y < b; y++) merge_interval(y, l, r);
                    shadow_clean = 0;
                    row_answer.push_back(make_result(STAT_DONE, 0, 0, 0, 1, shadow_clean));
                end
            end
            MODE_CLEAR: begin
                for (int y = 0; y < MAX_ROWS; y++) shadow_count[y] = 0;
                shadow_clean = 1;
                row_answer.push_back(make_result(STAT_DONE, 0, 0, 0, 1, shadow_clean));
            end
            MODE_READ: begin
                row = int'(it.read_row);
                if (row >= rows_in_use()) begin
                    row_answer.push_back(make_result(STAT_RANGE, 0, 0, 0, 1, shadow_clean));
                end else if (shadow_count[row] == 0) begin
                    row_answer.push_back(make_result(STAT_DONE, 0, 0, 0, 1, shadow_clean));
                end else begin
                    for (int k = 0; k < shadow_count[row]; k++)
                        row_answer.push_back(make_result(STAT_DONE, 1, shadow_lo[row][k],
                            shadow_hi[row][k], k + 1 == shadow_count[row], shadow_clean));
                end
            end
            default: begin
                row_answer.push_back(make_result(STAT_EMPTY, 0, 0, 0, 1, shadow_clean));
            end
        endcase
    endfunction

    // Hold start until the block takes the transaction, then record expectations
    task automatic issue(t_item it, bit typed, t_result answer);
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        apply_item(it);
        if (typed) expected_spans.push_back(answer);
        else foreach (row_answer[k]) expected_spans.push_back(row_answer[k]);
    endtask

    task automatic idle_burst(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_item <= t_item'($urandom);
        end
    endtask

    // Write a register once all answers are in and the block is idle
    task automatic write_reg(logic idx, int value);
        idle_burst(1);
        while (expected_spans.size() != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= X_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) shadow_width = value & 16'h1FFF;
        else shadow_height = value & 16'h7FF;
    endtask

    function automatic t_item random_item();
        int pick;
        int top;
        int left;
        int rows;
        pick = $urandom_range(0, 99);
        if (pick < 4) return t_item'({$urandom, $urandom, $urandom});
        if (pick < 6) return make_item(MODE_CLEAR, 0, 0, 0, 0, 0);
        if (pick < 8) return make_item(MODE_SPARE, $urandom, $urandom, $urandom, $urandom,
                                       $urandom);
        if (pick < 38) begin
            if ($urandom_range(0, 9) == 0)
                return make_item(MODE_READ, 0, 0, 0, 0, $urandom_range(0, 1023));
            return make_item(MODE_READ, 0, 0, 0, 0, $urandom_range(0, 9));
        end
        // Mostly short rectangles over a handful of rows, so rows fill up
        top = $urandom_range(0, 10) - 2;
        rows = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 1100) : $urandom_range(1, 4);
        left = $urandom_range(0, shadow_width + 4) - 4;
        if ($urandom_range(0, 3) == 0)
            return make_item(MODE_ADD, left, top, left + $urandom_range(0, 600), top + rows, 0);
        return make_item(MODE_ADD, left, top, left + $urandom_range(0, 12), top + rows, 0);
    endfunction

    // Compare each strobed answer against the oldest expectation
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_spans.size() == 0) begin
                $error("unexpected result transaction: status %0d", o_result.status);
                fail_count++;
            end else begin
                t_result want;
                want = expected_spans.pop_front();
                check_field("status", want.status, o_result.status);
                check_field("span_valid", want.span_valid, o_result.span_valid);
                check_field("span_start", want.span_start, o_result.span_start);
                check_field("span_stop", want.span_stop, o_result.span_stop);
                check_field("last", want.last, o_result.last);
                check_field("all_clean", want.all_clean, o_result.all_clean);
            end
        end
    end

    // Watchdog: count cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_directed(t_item it, bit typed, t_result answer);
        t_directed d;
        d.item = it;
        d.typed = typed;
        d.answer = answer;
        directed_rows.push_back(d);
    endtask

    initial begin
        t_result none;
        int      phase_width  [4];
        int      phase_height [4];
        none = '0;
        phase_width = '{4096, 1, 100, 4095};
        phase_height = '{1024, 1, 8, 3};
        fail_count = 0;
        stall_cycles = 0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_WIDTH;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        shadow_width = 4096;
        shadow_height = 1024;
        shadow_clean = 1;
        for (int y = 0; y < MAX_ROWS; y++) shadow_count[y] = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state, ignored items, extremes and merging cases
        add_directed(make_item(MODE_READ, 0, 0, 0, 0, 0), 1,
                     make_result(STAT_DONE, 0, 0, 0, 1, 1));
        add_directed(make_item(MODE_READ, 0, 0, 0, 0, 1023), 1,
                     make_result(STAT_DONE, 0, 0, 0, 1, 1));
        add_directed(make_item(MODE_ADD, 5, 0, 5, 3, 0), 1,
                     make_result(STAT_EMPTY, 0, 0, 0, 1, 1));
        add_directed(make_item(MODE_ADD, 0, 4, 10, 4, 0), 1,
                     make_result(STAT_EMPTY, 0, 0, 0, 1, 1));
        add_directed(make_item(MODE_ADD, 0, 1024, 10, 32767, 0), 1,
                     make_result(STAT_EMPTY, 0, 0, 0, 1, 1));
        add_directed(make_item(MODE_SPARE, -1, -1, -1, -1, 1023), 1,
                     make_result(STAT_EMPTY, 0, 0, 0, 1, 1));
        add_directed(make_item(MODE_ADD, -32768, -32768, 32767, 2, 0), 1,
                     make_result(STAT_DONE, 0, 0, 0, 1, 0));
        add_directed(make_item(MODE_READ, 0, 0, 0, 0, 1), 1,
                     make_result(STAT_DONE, 1, 0, 4096, 1, 0));
        add_directed(make_item(MODE_ADD, 10, 3, 20, 4, 0), 0, none);
        add_directed(make_item(MODE_ADD, 20, 3, 30, 4, 0), 0, none);
        add_directed(make_item(MODE_ADD, 40, 3, 50, 4, 0), 0, none);
        add_directed(make_item(MODE_ADD, 0, 3, 5, 4, 0), 0, none);
        add_directed(make_item(MODE_ADD, 4, 3, 45, 4, 0), 0, none);
        add_directed(make_item(MODE_ADD, 4090, 3, 4096, 4, 0), 0, none);
        add_directed(make_item(MODE_READ, 0, 0, 0, 0, 3), 0, none);
        add_directed(make_item(MODE_ADD, 100, 1020, 200, 32767, 0), 0, none);
        add_directed(make_item(MODE_READ, 0, 0, 0, 0, 1023), 0, none);
        add_directed(make_item(MODE_CLEAR, 0, 0, 0, 0, 0), 1,
                     make_result(STAT_DONE, 0, 0, 0, 1, 1));
        add_directed(make_item(MODE_READ, 0, 0, 0, 0, 3), 1,
                     make_result(STAT_DONE, 0, 0, 0, 1, 1));
        // Fill row 6 past capacity with separated spans to force the collapse
        for (int k = 0; k < MAX_SPANS + 1; k++)
            add_directed(make_item(MODE_ADD, 300 - 10 * k, 6, 304 - 10 * k, 7, 0), 0, none);
        add_directed(make_item(MODE_READ, 0, 0, 0, 0, 6), 0, none);

        foreach (directed_rows[k])
            issue(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].answer);

        // Random phases over several screen sizes
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_WIDTH, phase_width[p]);
            write_reg(CFG_HEIGHT, phase_height[p]);
            for (int k = 0; k < 120; k++) begin
                if (p < 3 && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 4));
                issue(random_item(), 0, none);
            end
        end

        // Drain outstanding answers
        idle_burst(1);
        while (expected_spans.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_spans.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
